[sv/aes_block_cipher_unit_macros.svh]
// ----------------------------------------------------------------------------
// aes block cipher unit assertion macros
// concurrent assertion shorthands clocked on rising edge, reset active low
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES_BLOCK_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define AESBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AESBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/aesbc_pkg.sv]
// ----------------------------------------------------------------------------
// aesbc_pkg
// shared types, substitution boxes and round functions of the aes unit
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int unsigned RK_ROWS   = 15;
    localparam int unsigned RK_AW     = $clog2(RK_ROWS);
    localparam int unsigned CFG_IW    = 3;
    localparam logic [3:0]  NR_128    = 4'd10;
    localparam logic [3:0]  NR_256    = 4'd14;

    localparam logic [CFG_IW-1:0] REG_KEY_W0     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_KEY_W1     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_KEY_W2     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_KEY_W3     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_KEY_LENGTH = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_req;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte 0 of the state sits in the top byte
    function automatic logic [127:0] byte_sub(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        o = '0;
        for (int b = 0; b < 16; b++) begin
            o[127-8*b -: 8] = inv ? INV_SBOX[s[127-8*b -: 8]] : SBOX[s[127-8*b -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [1:0]   src;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? 2'(c - r) : 2'(c + r);
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*int'(src)+r) -: 8];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0]   a  [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(4*c+k) -: 8];
                x2[k] = xt(a[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    // 14, 11, 13, 9 along the row
                    o[127-8*(4*c+r) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                        (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                        (x8[(r+3)%4] ^ a[(r+3)%4]);
                end else begin
                    o[127-8*(4*c+r) -: 8] =
                        x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
                end
            end
        end
        return o;
    endfunction

endpackage

[sv/aesbc_ram.sv]
// ----------------------------------------------------------------------------
// aesbc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module aesbc_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/aes_block_cipher_unit.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher_unit
// round-iterative aes-128/256 encrypt and decrypt with on-chip key expansion
// ----------------------------------------------------------------------------
//  channel   signals                                 handshake
//  request   start, busy, i_req                      start & !busy
//  result    o_res_valid, o_res                      one-cycle strobe, no stall
//  config    i_cfg_valid, o_cfg_ready, index, data   valid & ready
//
//  busy stays high for each request through a round-key ram read ahead, the
//  initial key add, nr rounds at one per cycle and the result strobe; the next
//  request is taken in the cycle after the strobe.
//  after reset or a key or length register write the first request first expands
//  the key, one 128-bit round-key row per cycle (11 or 15 rows).
//  reset is synchronous; the result cannot be stalled.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit
    import aesbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_res_valid,
    output t_res              o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    t_state r_state, n_state;

    logic [63:0]      r_key [4];
    logic             r_key_len;
    logic             r_keys_ready, n_keys_ready;
    logic             r_dec;
    logic [127:0]     r_s, n_s;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_rcon, n_rcon;
    logic [127:0]     r_prev1, r_prev2;

    logic [3:0]       nr;
    logic [RK_AW-1:0] rd_addr;
    logic [127:0]     rk_rdata;
    logic             rk_we;
    logic [127:0]     row;
    logic             last_round;
    logic             cfg_hit;

    assign nr          = r_key_len ? NR_256 : NR_128;
    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index <= REG_KEY_LENGTH);
    assign last_round  = (r_cnt == nr);

    // key schedule row for r_cnt
    always_comb begin
        logic [127:0] base;
        logic [31:0]  t;
        logic [31:0]  w0, w1, w2, w3;
        logic         rot;
        n_rcon = r_rcon;
        base   = r_key_len ? r_prev2 : r_prev1;
        rot    = !r_key_len || !r_cnt[0];
        t      = rot ? (sub_word({r_prev1[23:0], r_prev1[31:24]}) ^ {r_rcon, 24'h0})
                     : sub_word(r_prev1[31:0]);
        w0     = base[127:96] ^ t;
        w1     = base[95:64]  ^ w0;
        w2     = base[63:32]  ^ w1;
        w3     = base[31:0]   ^ w2;
        if (r_cnt == 4'd0) begin
            row = {r_key[0], r_key[1]};
        end else if (r_cnt == 4'd1 && r_key_len) begin
            row = {r_key[2], r_key[3]};
        end else begin
            row = {w0, w1, w2, w3};
            if (rot && r_state == ST_EXPAND) begin
                n_rcon = xt(r_rcon);
            end
        end
    end

    aesbc_ram #(
        .WIDTH (128),
        .DEPTH (RK_ROWS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (r_cnt[RK_AW-1:0]),
        .i_wdata (row),
        .i_raddr (rd_addr),
        .o_rdata (rk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = r_keys_ready ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (last_round) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (last_round) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [127:0] enc_v;
        logic [127:0] dec_v;
        n_s          = r_s;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        rk_we        = 1'b0;
        rd_addr      = '0;
        busy         = 1'b1;
        o_res_valid  = 1'b0;
        enc_v        = row_shift(byte_sub(r_s, 1'b0), 1'b0);
        if (!last_round) begin
            enc_v = column_mix(enc_v, 1'b0);
        end
        enc_v        = enc_v ^ rk_rdata;
        dec_v        = byte_sub(row_shift(r_s, 1'b1), 1'b1) ^ rk_rdata;
        if (!last_round) begin
            dec_v = column_mix(dec_v, 1'b1);
        end
        case (r_state)
            ST_IDLE: begin
                busy  = 1'b0;
                n_cnt = '0;
                if (start) begin
                    n_s = {i_req.block_hi, i_req.block_lo};
                end
            end
            ST_EXPAND: begin
                rk_we = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (last_round) begin
                    n_cnt        = '0;
                    n_keys_ready = 1'b1;
                end
            end
            ST_LOAD: begin
                rd_addr = r_dec ? nr[RK_AW-1:0] : '0;
            end
            ST_ROUND: begin
                // no row is fetched after the last round
                if (!last_round) begin
                    rd_addr = r_dec ? RK_AW'(nr - r_cnt - 4'd1) : RK_AW'(r_cnt + 4'd1);
                end
                n_cnt   = r_cnt + 4'd1;
                if (r_cnt == 4'd0) begin
                    n_s = r_s ^ rk_rdata;
                end else begin
                    n_s = r_dec ? dec_v : enc_v;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
        // a key write invalidates the expanded schedule
        if (cfg_hit) begin
            n_keys_ready = 1'b0;
        end
    end

    assign o_res.result_hi = r_s[127:64];
    assign o_res.result_lo = r_s[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_keys_ready <= 1'b0;
            r_key_len    <= 1'b0;
            r_cnt        <= '0;
            r_rcon       <= 8'h01;
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_cnt        <= n_cnt;
            r_rcon       <= (r_state == ST_IDLE) ? 8'h01 : n_rcon;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_KEY_W0:     r_key[0]  <= i_cfg_data;
                    REG_KEY_W1:     r_key[1]  <= i_cfg_data;
                    REG_KEY_W2:     r_key[2]  <= i_cfg_data;
                    REG_KEY_W3:     r_key[3]  <= i_cfg_data;
                    REG_KEY_LENGTH: r_key_len <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (r_state == ST_IDLE && start) begin
            r_dec <= i_req.req_type;
        end
        if (r_state == ST_EXPAND) begin
            r_prev2 <= r_prev1;
            r_prev1 <= row;
        end
    end

endmodule

[sv/aesbc_checker.sv]
// ----------------------------------------------------------------------------
// aesbc_checker
// port-level checks of the aes unit's request and result timing
// ----------------------------------------------------------------------------
`include "aes_block_cipher_unit_macros.svh"

module aesbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_res_valid
);

    `AESBC_ASSERT_NEXT(a_req_takes_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `AESBC_ASSERT_SAME(a_res_while_busy, i_clk, i_rst_n, o_res_valid, busy, "result while idle")
    `AESBC_ASSERT_NEXT(a_res_one_cycle, i_clk, i_rst_n, o_res_valid, !o_res_valid && !busy, "result strobe too long")
    `AESBC_ASSERT_NEXT(a_no_res_after_idle, i_clk, i_rst_n, !busy, !o_res_valid, "result without request")

endmodule

bind aes_block_cipher_unit aesbc_checker u_aesbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// aes block cipher unit testbench
// drives encrypt and decrypt requests under several keys and both key lengths,
// predicts each result with a behavioral aes model and checks it on the strobe
// ----------------------------------------------------------------------------
module testbench
    import aesbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REG_COUNT = 5;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_res_valid;
    t_res              o_res;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [63:0]       i_cfg_data;

    aes_block_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // model key registers and schedule
    logic [63:0] key_regs [4];
    logic        key_is_256;
    logic [31:0] sched [60];
    logic        sched_valid;

    t_res        cipher_expected [$];
    int          mismatch_count;
    int          idle_pct;
    logic [7:0]  sbox_t [256];
    logic [7:0]  inv_sbox_t [256];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #4ns i_clk = 1'b1;
        #4ns i_clk = 1'b0;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // substitution tables built from the field inverse and affine map
    task automatic build_sboxes();
        logic [7:0] inv, base, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            base = 8'(x);
            for (int e = 0; e < 8; e++) begin
                if (e != 0) inv = gf_mul(inv, base);
                base = gf_mul(base, base);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_t[x] = s;
            inv_sbox_t[s] = 8'(x);
        end
    endtask

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        return {sbox_t[w[31:24]], sbox_t[w[23:16]], sbox_t[w[15:8]], sbox_t[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        int nk, total;
        logic [7:0]  rc;
        logic [31:0] t;
        nk = key_is_256 ? 8 : 4;
        total = key_is_256 ? 60 : 44;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_dbl(rc);
            end else if (nk > 4 && i % nk == 4) begin
                t = sub_w(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    function automatic void xor_round_key(ref logic [7:0] s [16], input int rnd);
        logic [31:0] w;
        for (int c = 0; c < 4; c++) begin
            w = sched[4*rnd + c];
            for (int k = 0; k < 4; k++) s[4*c+k] ^= w[31-8*k -: 8];
        end
    endfunction

    function automatic void mix_columns(ref logic [7:0] s [16], input logic inv);
        logic [7:0] m [4];
        logic [7:0] a [4];
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
            for (int r = 0; r < 4; r++)
                s[4*c+r] = gf_mul(m[(4-r)%4], a[0]) ^ gf_mul(m[(5-r)%4], a[1])
                         ^ gf_mul(m[(6-r)%4], a[2]) ^ gf_mul(m[(7-r)%4], a[3]);
        end
    endfunction

    function automatic t_res aes_cipher(input t_req rq);
        logic [7:0] s [16];
        logic [7:0] t [16];
        int nr;
        t_res o;
        nr = key_is_256 ? 14 : 10;
        for (int i = 0; i < 8; i++) begin
            s[i] = rq.block_hi[63-8*i -: 8];
            s[8+i] = rq.block_lo[63-8*i -: 8];
        end
        if (!rq.req_type) begin
            xor_round_key(s, 0);
            for (int r = 1; r <= nr; r++) begin
                for (int i = 0; i < 16; i++) t[i] = sbox_t[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) s[4*c+w] = t[4*((c+w)%4)+w];
                if (r != nr) mix_columns(s, 1'b0);
                xor_round_key(s, r);
            end
        end else begin
            xor_round_key(s, nr);
            for (int r = nr; r >= 1; r--) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) t[4*c+w] = s[4*((c+4-w)%4)+w];
                for (int i = 0; i < 16; i++) s[i] = inv_sbox_t[t[i]];
                xor_round_key(s, r - 1);
                if (r != 1) mix_columns(s, 1'b1);
            end
        end
        for (int i = 0; i < 8; i++) begin
            o.result_hi[63-8*i -: 8] = s[i];
            o.result_lo[63-8*i -: 8] = s[8+i];
        end
        return o;
    endfunction

    // result checker: the strobe cannot be stalled
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_res_valid) begin
            if (cipher_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h_%h", o_res.result_hi, o_res.result_lo);
            end else begin
                exp_res = cipher_expected.pop_front();
                if (o_res.result_hi !== exp_res.result_hi
                    || o_res.result_lo !== exp_res.result_lo) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h_%h actual %h_%h",
                                 exp_res.result_hi, exp_res.result_lo,
                                 o_res.result_hi, o_res.result_lo);
                end
            end
        end
    end

    task automatic send_request(input t_req rq);
        do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        i_req <= rq;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (!sched_valid) expand_schedule();
        cipher_expected.push_back(aes_cipher(rq));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cipher_expected.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_KEY_W0: key_regs[0] = val;
            REG_KEY_W1: key_regs[1] = val;
            REG_KEY_W2: key_regs[2] = val;
            REG_KEY_W3: key_regs[3] = val;
            REG_KEY_LENGTH: key_is_256 = val[0];
            default: ;
        endcase
        if (idx < REG_COUNT) sched_valid = 1'b0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3, input logic len);
        wait_drained();
        write_reg(REG_KEY_W0, k0);
        write_reg(REG_KEY_W1, k1);
        write_reg(REG_KEY_W2, k2);
        write_reg(REG_KEY_W3, k3);
        write_reg(REG_KEY_LENGTH, {63'(0), len});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(5))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            3: return ~(64'h1 << $urandom_range(63));
            default: return rand64();
        endcase
    endfunction

    // reset key, then known vectors and field extremes for both lengths
    task automatic test_directed();
        t_req rq;
        send_request('{1'b0, 64'h0, 64'h0});
        send_request('{1'b1, 64'h0, 64'h0});
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1, 1'b0);
        send_request('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
        send_request('{1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
        send_request('{1'b0, '1, '1});
        send_request('{1'b1, '1, '1});
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f, 1'b1);
        send_request('{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff});
        send_request('{1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
        send_request('{1'b0, 64'h0, 64'h0});
        send_request('{1'b1, '1, 64'h0});
        load_key('1, '1, '1, '1, 1'b1);
        send_request('{1'b0, 64'h0, '1});
        send_request('{1'b1, 64'h8000000000000000, 64'h1});
        // an out-of-range index is ignored and keeps the expanded keys
        wait_drained();
        write_reg(3'd7, rand64());
        send_request('{1'b0, rand64(), rand64()});
        load_key(64'h0, 64'h0, 64'h0, 64'h0, 1'b0);
        send_request('{1'b0, '1, '1});
        send_request('{1'b1, 64'h0, 64'h0});
        for (int i = 0; i < 4; i++) begin
            rq = '{1'(i), edge64(), edge64()};
            send_request(rq);
        end
    endtask

    // random keys and blocks, with occasional encrypt/decrypt round trips
    task automatic test_random(input int n_items, input int pct);
        t_req rq;
        t_res ct;
        int sent;
        idle_pct = pct;
        sent = 0;
        while (sent < n_items) begin
            load_key(edge64(), edge64(), edge64(), edge64(), 1'($urandom_range(1)));
            for (int j = 0; j < 60 && sent < n_items; j++) begin
                rq = '{1'($urandom_range(1)), edge64(), edge64()};
                send_request(rq);
                sent++;
                if ($urandom_range(3) == 0 && sent < n_items) begin
                    ct = aes_cipher(rq);
                    send_request('{~rq.req_type, ct.result_hi, ct.result_lo});
                    sent++;
                end
                if ($urandom_range(40) == 0) begin
                    while (cipher_expected.size() != 0) @(negedge i_clk);
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        key_regs = '{default: '0};
        key_is_256 = 1'b0;
        sched_valid = 1'b0;
        mismatch_count = 0;
        idle_pct = 0;
        build_sboxes();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(630, 36);
        test_random(630, 76);
        test_random(630, 0);
        wait_drained();
        if (mismatch_count == 0 && cipher_expected.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
